/* rtl/core/ippcm_pkg.sv */
// ----------------------------------------------------------------------------
// ippcm_pkg: shared types and constants
// Command and status codes, table sizing and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ippcm_pkg;
  localparam int TableDepth = 256;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADLEN = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic [7:0] V4Max = 8'd32;
  localparam logic [7:0] V6Max = 8'd128;
  localparam logic [7:0] MapLen = 8'd96;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_READ, S_CMP, S_DONE
  } state_t;

  function automatic logic [63:0] top_mask(input logic [7:0] n);
    logic [63:0] m;
    begin
      if (n == 8'd0) m = '0;
      else if (n >= 8'd64) m = '1;
      else m = ~64'd0 << (7'd64 - {1'b0, n[5:0]});
      return m;
    end
  endfunction
endpackage
`default_nettype wire

/* rtl/core/ippcm_cmp.sv */
// ----------------------------------------------------------------------------
// ippcm_cmp: shared prefix compare unit
// Tests one stored network against the normalized address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ippcm_cmp (
  input  wire logic        fam,
  input  wire logic [63:0] hi,
  input  wire logic [63:0] lo,
  input  wire logic [8:0]  meta,
  input  wire logic [63:0] net_hi,
  input  wire logic [63:0] net_lo,
  output logic             hit
);
  logic [63:0] mh, ml, m4;
  logic [7:0] np;
  always_comb begin
    np = meta[7:0];
    m4 = ippcm_pkg::top_mask(np);
    if (!fam) begin
      mh = '0;
      ml = {32'd0, m4[63:32]};
    end else if (np >= 8'd64) begin
      mh = '1;
      ml = ippcm_pkg::top_mask(np - 8'd64);
    end else begin
      mh = m4;
      ml = '0;
    end
    hit = (meta[8] == fam) && (((hi ^ net_hi) & mh) == 64'd0)
          && (((lo ^ net_lo) & ml) == 64'd0);
  end
endmodule
`default_nettype wire

/* rtl/core/ip_prefix_containment_match.sv */
// ----------------------------------------------------------------------------
// ip_prefix_containment_match: IPv4/IPv6 prefix table
// Stores up to 256 networks; answers clear, insert and containment queries.
// ----------------------------------------------------------------------------
// Input words arrive on s_axis; one result word leaves on m_axis per input.
// Clear, insert, unused commands, bad lengths and queries on an empty table
// pass from the decode state straight to the done state, which presents the
// result. A query walks the stored entries one per cycle through the single
// compare unit and the registered table read port (read state, then compare
// state for each entry) and ends early on a hit.
// s_axis_tready is high only in idle, one word at a time.
// A result waits in its output register until m_axis_tready; no new word is
// taken meanwhile. Reset empties the table (entry count to zero); no clearing
// pass runs, table contents are undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ip_prefix_containment_match (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // cmd[1:0], family[2], addr_high[66:3], addr_low[130:67], prefix_len[138:131]
  input  wire logic [143:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // contained[0], status[2:1]
  output logic [7:0]        m_axis_tdata
);
  ippcm_pkg::state_t state, state_next;
  logic [63:0] mem_hi [ippcm_pkg::TableDepth];
  logic [63:0] mem_lo [ippcm_pkg::TableDepth];
  logic [8:0]  mem_meta [ippcm_pkg::TableDepth];
  logic [ippcm_pkg::CntW-1:0] entry_count, idx;
  logic [1:0] cmd, status;
  logic fam, bad, hit, contained;
  logic [63:0] hi, lo, rd_hi, rd_lo;
  logic [8:0] rd_meta;
  logic [7:0] plen;
  logic rd_valid, wr_en;
  logic fam_in, bad_in;
  logic [63:0] hi_in, lo_in;
  logic [7:0] plen_in;

  ippcm_cmp u_cmp (.fam(fam), .hi(hi), .lo(lo), .meta(rd_meta),
                   .net_hi(rd_hi), .net_lo(rd_lo), .hit(hit));

  assign s_axis_tready = (state == ippcm_pkg::S_IDLE);
  assign m_axis_tdata = {5'd0, status, contained};
  assign wr_en = (state == ippcm_pkg::S_DECODE) && (cmd == ippcm_pkg::CMD_INSERT) && !bad
                 && (entry_count != ippcm_pkg::CntW'(ippcm_pkg::TableDepth));

  always_comb begin
    fam_in = s_axis_tdata[2];
    hi_in = s_axis_tdata[66:3];
    lo_in = s_axis_tdata[130:67];
    plen_in = s_axis_tdata[138:131];
    bad_in = 1'b0;
    if (!fam_in) begin
      bad_in = plen_in > ippcm_pkg::V4Max;
      hi_in = '0;
      lo_in = {32'd0, lo_in[31:0]};
    end else if (plen_in > ippcm_pkg::V6Max) begin
      bad_in = 1'b1;
    end else if (plen_in >= ippcm_pkg::MapLen && hi_in == 64'd0
                 && lo_in[63:32] == 32'h0000ffff) begin
      fam_in = 1'b0;
      lo_in = {32'd0, lo_in[31:0]};
      plen_in = plen_in - ippcm_pkg::MapLen;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ippcm_pkg::S_IDLE: if (s_axis_tvalid) state_next = ippcm_pkg::S_DECODE;
      ippcm_pkg::S_DECODE: begin
        if (cmd == ippcm_pkg::CMD_QUERY && !bad && entry_count != '0)
          state_next = ippcm_pkg::S_READ;
        else state_next = ippcm_pkg::S_DONE;
      end
      ippcm_pkg::S_READ: state_next = ippcm_pkg::S_CMP;
      ippcm_pkg::S_CMP: begin
        if (hit || idx == entry_count) state_next = ippcm_pkg::S_DONE;
      end
      ippcm_pkg::S_DONE: if (m_axis_tready) state_next = ippcm_pkg::S_IDLE;
      default: state_next = ippcm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    m_axis_tvalid = (state == ippcm_pkg::S_DONE);
    rd_valid = (state == ippcm_pkg::S_READ)
               || (state == ippcm_pkg::S_CMP && idx != entry_count);
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      rd_hi <= mem_hi[idx[ippcm_pkg::IdxW-1:0]];
      rd_lo <= mem_lo[idx[ippcm_pkg::IdxW-1:0]];
      rd_meta <= mem_meta[idx[ippcm_pkg::IdxW-1:0]];
    end
    if (wr_en) begin
      mem_hi[entry_count[ippcm_pkg::IdxW-1:0]] <= hi;
      mem_lo[entry_count[ippcm_pkg::IdxW-1:0]] <= lo;
      mem_meta[entry_count[ippcm_pkg::IdxW-1:0]] <= {fam, plen};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ippcm_pkg::S_IDLE;
      entry_count <= '0;
      idx <= '0;
      status <= ippcm_pkg::ST_OK;
      contained <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ippcm_pkg::S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd <= s_axis_tdata[1:0];
            plen <= plen_in;
            hi <= hi_in;
            lo <= lo_in;
            fam <= fam_in;
            bad <= bad_in;
            status <= ippcm_pkg::ST_OK;
            contained <= 1'b0;
            idx <= '0;
          end
        end
        ippcm_pkg::S_DECODE: begin
          case (cmd)
            ippcm_pkg::CMD_CLEAR: entry_count <= '0;
            ippcm_pkg::CMD_INSERT: begin
              if (bad) status <= ippcm_pkg::ST_BADLEN;
              else if (!wr_en) status <= ippcm_pkg::ST_FULL;
              else entry_count <= entry_count + 1'b1;
            end
            ippcm_pkg::CMD_QUERY: if (bad) status <= ippcm_pkg::ST_BADLEN;
            default: status <= ippcm_pkg::ST_OK;
          endcase
        end
        ippcm_pkg::S_READ: idx <= idx + 1'b1;
        ippcm_pkg::S_CMP: begin
          if (hit) contained <= 1'b1;
          else if (idx != entry_count) idx <= idx + 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
